### rtl/slxfr_pkg.sv
// ----------------------------------------------------------------------------
// slxfr_pkg
// Shared constants and types of the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

  // Payload store depth and the address width that follows from it.
  localparam int BufDepth = 64;
  localparam int AddrW    = $clog2(BufDepth);

  localparam int ByteW = 8;
  localparam int MaxLW = 7;
  localparam int CfgIW = 2;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'h4C;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h4D;
  localparam logic [MaxLW-1:0] MaxLenRst     = 7'd40;

  // Configuration register indexes.
  localparam logic [CfgIW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIW-1:0] CfgSyncSecond = 2'd1;
  localparam logic [CfgIW-1:0] CfgMaxLength  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_frame;     // length byte taken: load need, clear count and XOR
    logic store;         // payload byte taken
    logic emit_start;    // checksum matched on a non-empty frame
    logic rd_en;         // read the store at the emit index
    logic idx_inc;       // step the emit index
    logic load_data;     // load a payload result
    logic load_ok_empty; // load the result of a good empty frame
    logic load_err;      // load the error result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic len_bad;
    logic at_chk;
    logic chk_match;
    logic count_zero;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/slxfr_dp.sv
// ----------------------------------------------------------------------------
// slxfr_dp
// Datapath: configuration registers, frame counters, running XOR, payload
// store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slxfr_pkg::CfgIW-1:0]   cfg_idx_i,
  input  wire logic [slxfr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  wire logic [slxfr_pkg::ByteW-1:0]   rx_byte_i,
  input  wire slxfr_pkg::cmd_t               cmd_i,
  output slxfr_pkg::status_t                 status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [slxfr_pkg::ByteW-1:0]        byte_value_o,
  output logic                               has_byte_o,
  output logic                               frame_ok_o,
  output logic                               last_of_run_o
);

  localparam int AW = slxfr_pkg::AddrW;
  localparam int BW = slxfr_pkg::ByteW;

  logic [BW-1:0]                 sync_first_q;
  logic [BW-1:0]                 sync_second_q;
  logic [slxfr_pkg::MaxLW-1:0]   max_len_q;

  logic [AW-1:0] need_q;
  logic [AW-1:0] count_q;
  logic [AW-1:0] idx_q;
  logic [BW-1:0] xor_q;
  logic [BW-1:0] seq_q;
  logic [BW-1:0] rd_data_q;

  logic [BW-1:0] mem [slxfr_pkg::BufDepth];

  logic          out_valid_q;
  logic [BW-1:0] byte_value_q;
  logic          has_byte_q;
  logic          frame_ok_q;
  logic          last_q;

  logic [AW-1:0] len_m1;
  logic          load_any;

  assign len_m1   = rx_byte_i[AW-1:0] - AW'(1);
  assign load_any = cmd_i.load_data | cmd_i.load_ok_empty | cmd_i.load_err;

  always_comb begin
    status_o.sync1_hit  = (rx_byte_i == sync_first_q);
    status_o.sync2_hit  = (rx_byte_i == sync_second_q);
    status_o.len_bad    = (rx_byte_i > {1'b0, max_len_q}) ||
                          ({1'b0, rx_byte_i} > (BW+1)'(slxfr_pkg::BufDepth));
    status_o.at_chk     = (count_q == need_q);
    status_o.chk_match  = (rx_byte_i == xor_q);
    status_o.count_zero = (count_q == '0);
    status_o.emit_last  = (idx_q == count_q - AW'(1));
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slxfr_pkg::SyncFirstRst;
      sync_second_q <= slxfr_pkg::SyncSecondRst;
      max_len_q     <= slxfr_pkg::MaxLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slxfr_pkg::CfgSyncFirst:  sync_first_q  <= cfg_wdata_i;
        slxfr_pkg::CfgSyncSecond: sync_second_q <= cfg_wdata_i;
        slxfr_pkg::CfgMaxLength:  max_len_q     <= cfg_wdata_i[slxfr_pkg::MaxLW-1:0];
        default: ;
      endcase
    end
  end

  // Frame counters and checksum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      xor_q   <= '0;
    end else begin
      if (cmd_i.clr_frame) begin
        // A length of zero or one leaves nothing to store.
        need_q  <= (rx_byte_i == '0) ? '0 : len_m1;
        count_q <= '0;
        xor_q   <= '0;
      end else if (cmd_i.store) begin
        count_q <= count_q + AW'(1);
        if (count_q != '0) begin
          xor_q <= xor_q ^ rx_byte_i;
        end
      end
      if (cmd_i.emit_start) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  // The sequence byte is kept aside so that an error result needs no read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && count_q == '0) begin
      seq_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[count_q] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.load_data) begin
      byte_value_q <= rd_data_q;
      has_byte_q   <= 1'b1;
      frame_ok_q   <= 1'b1;
      last_q       <= status_o.emit_last;
    end else if (cmd_i.load_ok_empty) begin
      byte_value_q <= '0;
      has_byte_q   <= 1'b0;
      frame_ok_q   <= 1'b1;
      last_q       <= 1'b1;
    end else if (cmd_i.load_err) begin
      byte_value_q <= (count_q == '0) ? '0 : seq_q;
      has_byte_q   <= 1'b0;
      frame_ok_q   <= 1'b0;
      last_q       <= 1'b1;
    end else begin
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_value_o  = byte_value_q;
  assign has_byte_o    = has_byte_q;
  assign frame_ok_o    = frame_ok_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

### rtl/slxfr_ctrl.sv
// ----------------------------------------------------------------------------
// slxfr_ctrl
// Controller: frame hunt, reception and result emission sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire slxfr_pkg::status_t   status_i,
  output slxfr_pkg::cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    S_SYNC1,
    S_SYNC2,
    S_LEN,
    S_DATA,
    S_READ,
    S_PUT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   fire;

  always_comb begin
    unique case (state_q)
      S_SYNC1, S_SYNC2, S_LEN: in_ready_o = 1'b1;
      // The checksum byte needs a free output register for its result.
      S_DATA:  in_ready_o = !status_i.at_chk || status_i.out_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_SYNC1: begin
        if (fire && status_i.sync1_hit) begin
          state_d = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (fire) begin
          state_d = status_i.sync2_hit ? S_LEN : S_SYNC1;
        end
      end
      S_LEN: begin
        if (fire) begin
          cmd_o.clr_frame = 1'b1;
          state_d = status_i.len_bad ? S_SYNC1 : S_DATA;
        end
      end
      S_DATA: begin
        if (fire) begin
          priority if (!status_i.at_chk) begin
            cmd_o.store = 1'b1;
          end else if (status_i.chk_match && !status_i.count_zero) begin
            cmd_o.emit_start = 1'b1;
            state_d = S_READ;
          end else if (status_i.chk_match) begin
            cmd_o.load_ok_empty = 1'b1;
            state_d = S_SYNC1;
          end else begin
            cmd_o.load_err = 1'b1;
            state_d = S_SYNC1;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_PUT;
      end
      S_PUT: begin
        if (status_i.out_free) begin
          cmd_o.load_data = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_SYNC1;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_SYNC1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sync_length_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Deframer for two-sync-byte, length-prefixed frames with an XOR checksum.
//
// Usage: received bytes enter on the rx channel (in_valid_i/in_ready_o),
// results leave on the output channel (out_valid_o/out_ready_i); each side
// moves one item per transfer. Sync bytes and the length limit are set on
// the write port; the user must write them only while the block is idle,
// as the block itself does not enforce it. Reception takes one byte per
// cycle outside a drain. The checksum byte is taken only when the output
// register is free or being emptied in that cycle. A good frame with N
// stored bytes then drains as N results, one store read and one output
// load per result, and no byte is taken meanwhile; each result is read
// from the store, then loaded into the output register when free. Empty and
// error frames load their single result at the checksum transfer itself.
// A stalled receiver holds the output register and so the drain sequencer.
// Reset returns to the hunt for the first sync byte and restores the
// default sync bytes and length limit; the payload store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_receiver (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slxfr_pkg::CfgIW-1:0]   cfg_idx_i,
  input  wire logic [slxfr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [slxfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [slxfr_pkg::ByteW-1:0]        byte_value_o,
  output logic                               has_byte_o,
  output logic                               frame_ok_o,
  output logic                               last_of_run_o
);

  slxfr_pkg::cmd_t    cmd;
  slxfr_pkg::status_t status;

  slxfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slxfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .byte_value_o  (byte_value_o),
    .has_byte_o    (has_byte_o),
    .frame_ok_o    (frame_ok_o),
    .last_of_run_o (last_of_run_o)
  );

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_data, cmd.load_ok_empty, cmd.load_err}))
    else $error("more than one result load in a cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_data || cmd.load_ok_empty || cmd.load_err) |-> status.out_free)
    else $error("result loaded over a pending result");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_byte_o) |-> frame_ok_o)
    else $error("payload result without a good checksum");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |-> (last_of_run_o && !has_byte_o))
    else $error("error result is not a single closing result");

endmodule

`default_nettype wire
